@@ rtl/spq_pkg.sv @@
// ---------------------------------------------------------------------------
// Sorted priority queue package
// Shared default sizes, request codes and status codes for the queue core.
// ---------------------------------------------------------------------------
package spq_pkg;

  // Default sizes handed to the core's parameters.
  localparam int DEF_CAPACITY     = 16;
  localparam int DEF_KEY_BITS     = 16;
  localparam int DEF_PAYLOAD_BITS = 16;

  // Fixed field widths.
  localparam int REQ_BITS    = 2;
  localparam int STATUS_BITS = 2;

  // Request codes.
  typedef enum logic [REQ_BITS-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  // Result status codes.
  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

endpackage

@@ rtl/sorted_priority_queue_core.sv @@
// ---------------------------------------------------------------------------
// Sorted priority queue core
// Keeps key/payload entries in ascending key order in one circular memory.
// ---------------------------------------------------------------------------
// The queue holds up to CAPACITY entries in a single synchronous memory
// (one read and one write port, registered read data), laid out as a ring
// that starts at the head slot. One request is worked on at a time. A push
// walks from the tail toward the head, moving every entry whose key is not
// smaller than the new key up by one slot, so a new entry goes ahead of
// entries with an equal key; each move is one memory read and one write
// back. When every held entry has a key not smaller than the new one, the
// new entry goes straight into the head slot without a final read. Pop
// and peek read the head slot. A push to a full queue, a pop or peek on
// an empty queue, and the unused request code need no memory access.
// Every request gives exactly one result transaction carrying status and
// occupancy. The result sits in an output register, so the next request
// is accepted while the previous result still waits to be taken; a
// request whose result is ready while that register is still occupied
// waits for as long as the output side stalls.
// ---------------------------------------------------------------------------
module sorted_priority_queue_core #(
  parameter int CAPACITY     = spq_pkg::DEF_CAPACITY,
  parameter int KEY_BITS     = spq_pkg::DEF_KEY_BITS,
  parameter int PAYLOAD_BITS = spq_pkg::DEF_PAYLOAD_BITS,
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CNT_W       = $clog2(CAPACITY + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [spq_pkg::REQ_BITS-1:0]    in_req_type,
  input  logic [KEY_BITS-1:0]             in_entry_key,
  input  logic [PAYLOAD_BITS-1:0]         in_entry_payload,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [spq_pkg::STATUS_BITS-1:0] out_status,
  output logic [KEY_BITS-1:0]             out_key,
  output logic [PAYLOAD_BITS-1:0]         out_payload,
  output logic [CNT_W-1:0]                out_occupancy
);

  localparam int ENTRY_W = KEY_BITS + PAYLOAD_BITS;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_CMP   = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  // Ring position of an offset from the head; the sum stays below twice
  // the capacity, so one compare and subtract wraps it.
  function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(head) + {1'b0, off};
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Control state
  state_t                          state_r, state_nxt;
  logic [IDX_W-1:0]                head_r, head_nxt;
  logic [CNT_W-1:0]                count_r, count_nxt;
  logic                            out_valid_r, out_valid_nxt;

  // Request and working registers
  logic [spq_pkg::REQ_BITS-1:0]    req_r, req_nxt;
  logic [KEY_BITS-1:0]             key_r, key_nxt;
  logic [PAYLOAD_BITS-1:0]         pay_r, pay_nxt;
  logic [CNT_W-1:0]                pos_r, pos_nxt;
  logic [spq_pkg::STATUS_BITS-1:0] res_status_r, res_status_nxt;
  logic [KEY_BITS-1:0]             res_key_r, res_key_nxt;
  logic [PAYLOAD_BITS-1:0]         res_pay_r, res_pay_nxt;

  // Output registers
  logic [spq_pkg::STATUS_BITS-1:0] out_status_r, out_status_nxt;
  logic [KEY_BITS-1:0]             out_key_r, out_key_nxt;
  logic [PAYLOAD_BITS-1:0]         out_pay_r, out_pay_nxt;
  logic [CNT_W-1:0]                out_occ_r, out_occ_nxt;

  // Entry memory and its port controls
  logic [ENTRY_W-1:0]              mem_r [CAPACITY];
  logic [ENTRY_W-1:0]              rd_data_r;
  logic                            rd_en;
  logic [IDX_W-1:0]                rd_addr;
  logic                            wr_en;
  logic [IDX_W-1:0]                wr_addr;
  logic [ENTRY_W-1:0]              wr_data;

  logic                            in_accept;
  logic                            out_free;
  logic [KEY_BITS-1:0]             rd_key;
  logic [PAYLOAD_BITS-1:0]         rd_pay;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign rd_key    = rd_data_r[ENTRY_W-1:PAYLOAD_BITS];
  assign rd_pay    = rd_data_r[PAYLOAD_BITS-1:0];

  // Sequencer: decode, tail-to-head insertion walk, head fetch, result load.
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    pay_nxt        = pay_r;
    pos_nxt        = pos_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_pay_nxt    = res_pay_r;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_pay_nxt    = out_pay_r;
    out_occ_nxt    = out_occ_r;
    rd_en          = 1'b0;
    rd_addr        = head_r;
    wr_en          = 1'b0;
    wr_addr        = slot_at(head_r, pos_r);
    wr_data        = {key_r, pay_r};

    // A taken result frees the output register.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          req_nxt        = in_req_type;
          key_nxt        = in_entry_key;
          pay_nxt        = in_entry_payload;
          pos_nxt        = count_r;
          res_status_nxt = spq_pkg::STATUS_OK;
          res_key_nxt    = '0;
          res_pay_nxt    = '0;
          case (in_req_type)
            spq_pkg::REQ_PUSH: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                res_status_nxt = spq_pkg::STATUS_FULL;
                state_nxt      = ST_DONE;
              end else begin
                state_nxt = ST_READ;
              end
            end
            spq_pkg::REQ_POP, spq_pkg::REQ_PEEK: begin
              if (count_r == '0) begin
                res_status_nxt = spq_pkg::STATUS_EMPTY;
                state_nxt      = ST_DONE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = head_r;
                state_nxt = ST_FETCH;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // Read the entry just below the open slot, or drop the new entry
      // into the head slot when the walk has reached it.
      ST_READ: begin
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          wr_addr   = slot_at(head_r, pos_r);
          wr_data   = {key_r, pay_r};
          count_nxt = count_r + 1'b1;
          state_nxt = ST_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = slot_at(head_r, pos_r - 1'b1);
          state_nxt = ST_CMP;
        end
      end

      // Move a not-smaller entry up one slot, or place the new entry.
      ST_CMP: begin
        wr_en   = 1'b1;
        wr_addr = slot_at(head_r, pos_r);
        if (rd_key >= key_r) begin
          wr_data   = rd_data_r;
          pos_nxt   = pos_r - 1'b1;
          state_nxt = ST_READ;
        end else begin
          wr_data   = {key_r, pay_r};
          count_nxt = count_r + 1'b1;
          state_nxt = ST_DONE;
        end
      end

      // Head entry is back from memory.
      ST_FETCH: begin
        res_key_nxt = rd_key;
        res_pay_nxt = rd_pay;
        if (req_r == spq_pkg::REQ_POP) begin
          head_nxt  = slot_at(head_r, CNT_W'(1));
          count_nxt = count_r - 1'b1;
        end
        state_nxt = ST_DONE;
      end

      // Hand the result over once the output register is free.
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = res_key_r;
          out_pay_nxt    = res_pay_r;
          out_occ_nxt    = count_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    pay_r        <= pay_nxt;
    pos_r        <= pos_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_pay_r    <= res_pay_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_pay_r    <= out_pay_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  // Entry memory: one write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key       = out_key_r;
  assign out_payload   = out_pay_r;
  assign out_occupancy = out_occ_r;

endmodule
